/* hw/rtl/i2cee_pkg.sv */
`default_nettype none
package i2cee_pkg;

  // payload widths
  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 16;
  localparam int LEN_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int ST_W    = 3;
  localparam int ACT_W   = 4;
  localparam int DEV_W   = 7;
  localparam int POLL_W  = 16;
  localparam int CHUNK_W = 9;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // transfer geometry (powers of two)
  localparam int PAGE_SIZE  = 16;
  localparam int READ_BLOCK = 256;

  // result queue
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int FIFO_DEPTH = 8;

  localparam logic [DEV_W-1:0]  DEVICE_BASE_RST = DEV_W'(80);
  localparam logic [POLL_W-1:0] POLL_LIMIT_RST  = POLL_W'(1000);

  // commands
  localparam logic [CMD_W-1:0] CMD_SPLIT_WR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SINGLE_WR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HOST_BYTE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STATUS    = 3'd4;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_SPLIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAGE  = 2'd1;

  // bus status codes
  localparam logic [ST_W-1:0] ST_START_OK  = 3'd0;
  localparam logic [ST_W-1:0] ST_RSTART_OK = 3'd1;
  localparam logic [ST_W-1:0] ST_WADDR_ACK = 3'd2;
  localparam logic [ST_W-1:0] ST_DATA_ACK  = 3'd3;
  localparam logic [ST_W-1:0] ST_RADDR_ACK = 3'd4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT  = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_START     = 4'd0,
    ACT_RSTART    = 4'd1,
    ACT_STOP      = 4'd2,
    ACT_SEND      = 4'd3,
    ACT_RECV_ACK  = 4'd4,
    ACT_RECV_NACK = 4'd5,
    ACT_READ      = 4'd6,
    ACT_OK        = 4'd7,
    ACT_ERR       = 4'd8
  } act_t;

  typedef enum logic [13:0] {
    PH_IDLE     = 14'b00000000000001,
    PH_W_START  = 14'b00000000000010,
    PH_W_DEV    = 14'b00000000000100,
    PH_W_WORD   = 14'b00000000001000,
    PH_W_WAIT   = 14'b00000000010000,
    PH_W_DATA   = 14'b00000000100000,
    PH_P_START  = 14'b00000001000000,
    PH_P_DEV    = 14'b00000010000000,
    PH_R_START  = 14'b00000100000000,
    PH_R_DEV    = 14'b00001000000000,
    PH_R_WORD   = 14'b00010000000000,
    PH_R_RSTART = 14'b00100000000000,
    PH_R_RDEV   = 14'b01000000000000,
    PH_R_DATA   = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    act_t              action;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]  n;
    res_t [MAX_RES-1:0]    res;
  } push_t;

  function automatic res_t mk_res(act_t act, logic [BYTE_W-1:0] b);
    res_t r;
    r.action   = act;
    r.out_byte = b;
    r.last     = 1'b0;
    return r;
  endfunction

  // 8-bit device address word: (base | addr[10:8]) << 1 | rw
  function automatic logic [BYTE_W-1:0] dev_byte(logic [DEV_W-1:0] base,
                                                 logic [ADDR_W-1:0] addr,
                                                 logic rw);
    logic [DEV_W-1:0] dev;
    dev = base | {4'b0000, addr[10:8]};
    return {dev, rw};
  endfunction

  function automatic logic [LEN_W-1:0] write_chunk(logic [KIND_W-1:0] kind,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic [LEN_W-1:0] rem);
    logic [LEN_W-1:0] space;
    space = LEN_W'(PAGE_SIZE) - LEN_W'(addr % ADDR_W'(PAGE_SIZE));
    if (kind == KIND_PAGE) return rem;
    return (rem < space) ? rem : space;
  endfunction

  function automatic logic [CHUNK_W-1:0] read_chunk(logic [ADDR_W-1:0] addr,
                                                    logic [LEN_W-1:0] rem);
    logic [LEN_W-1:0] space;
    space = LEN_W'(READ_BLOCK) - LEN_W'(addr % ADDR_W'(READ_BLOCK));
    return (rem < space) ? rem[CHUNK_W-1:0] : space[CHUNK_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/i2cee_if.sv */
`default_nettype none
interface i2cee_in_if
  import i2cee_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] start_address;
  logic [LEN_W-1:0]  transfer_length;
  logic [BYTE_W-1:0] data_byte;
  logic [ST_W-1:0]   bus_status;

  modport source (output valid, command, start_address, transfer_length, data_byte,
                  bus_status, input ready);
  modport sink   (input valid, command, start_address, transfer_length, data_byte,
                  bus_status, output ready);
endinterface

interface i2cee_out_if
  import i2cee_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, action, out_byte, last, input ready);
  modport sink   (input valid, action, out_byte, last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/i2cee_res_fifo.sv */
`default_nettype none
module i2cee_res_fifo
  import i2cee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire push_t    push,
  output logic          room,
  i2cee_out_if.source   out_ch
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  res_t               mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;
  res_t               head;

  assign pop  = out_ch.valid && out_ch.ready;
  // room for a full burst of results from one word
  assign room = (count_r <= CNT_W'(FIFO_DEPTH - MAX_RES));

  assign head            = mem[rd_ptr_r];
  assign out_ch.valid    = (count_r != '0);
  assign out_ch.action   = head.action;
  assign out_ch.out_byte = head.out_byte;
  assign out_ch.last     = head.last;

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push.n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CNT_W'(k) < push.n) begin
        mem[wr_ptr_r + PTR_W'(k)] <= push.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != '0 |-> room)
    else $error("results pushed without room");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r == $past(count_r) + CNT_W'($past(push.n)) - CNT_W'($past(pop)))
    else $error("queue count out of step with push and pop");

endmodule
`default_nettype wire

/* hw/rtl/i2c_eeprom_transfer_sequencer.sv */
// Results of an accepted word pass through the registered result queue to out_ch,
//   one result word per cycle while out_ch.ready is high, up to three per input word.
// Throughput: one input word per cycle while the 8-entry result queue holds four
//   or fewer words; the queue drain rate (one per cycle) sets the sustained rate.
// Reset (rst_n low, synchronous): sequencer idle, address/count state cleared,
//   device_base = 80, poll_limit = 1000, result queue empty.
`default_nettype none
module i2c_eeprom_transfer_sequencer
  import i2cee_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  i2cee_in_if.sink                   in_ch,
  i2cee_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [DEV_W-1:0]   device_base_r;
  logic [POLL_W-1:0]  poll_limit_r;

  phase_t             phase_r, phase_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [POLL_W-1:0]  polls_r, polls_nxt;

  logic               room;
  logic               in_fire;
  push_t              push;
  res_t [MAX_RES-1:0] res;
  logic [RES_CNT_W-1:0] n_cnt;

  // precomputed next-chunk terms
  logic [LEN_W-1:0]   wc, wc2, new_wc;
  logic [ADDR_W-1:0]  addr_step, addr_inc;
  logic [LEN_W-1:0]   rem_step, rem_dec;
  logic [CHUNK_W-1:0] chunk_dec, rc2, new_rc;
  logic [POLL_W-1:0]  polls_dec, poll_load;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_base_r <= DEVICE_BASE_RST;
      poll_limit_r  <= POLL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEVICE_BASE: device_base_r <= cfg_wdata[DEV_W-1:0];
        REG_POLL_LIMIT:  poll_limit_r  <= cfg_wdata[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  assign wc        = write_chunk(kind_r, addr_r, rem_r);
  assign addr_step = addr_r + wc;
  assign rem_step  = rem_r - wc;
  assign wc2       = write_chunk(kind_r, addr_step, rem_step);
  assign addr_inc  = addr_r + ADDR_W'(1);
  assign rem_dec   = rem_r - LEN_W'(1);
  assign chunk_dec = chunk_r - CHUNK_W'(1);
  assign rc2       = read_chunk(addr_inc, rem_dec);
  assign polls_dec = polls_r - POLL_W'(1);
  assign poll_load = (poll_limit_r != '0) ? poll_limit_r : POLL_W'(1);
  assign new_wc    = write_chunk(in_ch.command[KIND_W-1:0], in_ch.start_address,
                                 in_ch.transfer_length);
  assign new_rc    = read_chunk(in_ch.start_address, in_ch.transfer_length);

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    chunk_nxt = chunk_r;
    polls_nxt = polls_r;
    n_cnt     = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = mk_res(ACT_START, '0);
    end

    if (in_fire) begin
      priority if (phase_r == PH_IDLE) begin
        if (in_ch.command <= CMD_READ) begin
          kind_nxt = in_ch.command[KIND_W-1:0];
          addr_nxt = in_ch.start_address;
          rem_nxt  = in_ch.transfer_length;
          if (in_ch.command == CMD_SINGLE_WR && (in_ch.transfer_length == '0 ||
              in_ch.transfer_length > LEN_W'(PAGE_SIZE))) begin
            res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
          end else if (in_ch.transfer_length == '0) begin
            res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_OK, '0); n_cnt = n_cnt + 1'b1;
          end else if (in_ch.command == CMD_READ) begin
            chunk_nxt = new_rc;
            res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_START, '0); n_cnt = n_cnt + 1'b1;
            phase_nxt = PH_R_START;
          end else begin
            chunk_nxt = new_wc[CHUNK_W-1:0];
            res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_START, '0); n_cnt = n_cnt + 1'b1;
            phase_nxt = PH_W_START;
          end
        end
      end else if (phase_r == PH_W_WAIT) begin
        if (in_ch.command == CMD_HOST_BYTE) begin
          res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_SEND, in_ch.data_byte);
          n_cnt = n_cnt + 1'b1;
          phase_nxt = PH_W_DATA;
        end
      end else if (in_ch.command == CMD_STATUS) begin
        unique case (phase_r)
          PH_W_START, PH_R_START: begin
            if (in_ch.bus_status != ST_START_OK) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_SEND,
                                                 dev_byte(device_base_r, addr_r, 1'b0));
              n_cnt = n_cnt + 1'b1;
              phase_nxt = (phase_r == PH_W_START) ? PH_W_DEV : PH_R_DEV;
            end
          end
          PH_W_DEV, PH_R_DEV: begin
            if (in_ch.bus_status != ST_WADDR_ACK) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_SEND, addr_r[BYTE_W-1:0]);
              n_cnt = n_cnt + 1'b1;
              phase_nxt = (phase_r == PH_W_DEV) ? PH_W_WORD : PH_R_WORD;
            end
          end
          PH_W_WORD: begin
            if (in_ch.bus_status != ST_DATA_ACK) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_W_WAIT;  // wait silently for the host byte
            end
          end
          PH_W_DATA: begin
            if (in_ch.bus_status != ST_DATA_ACK) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              chunk_nxt = chunk_dec;
              if (chunk_dec != '0) begin
                phase_nxt = PH_W_WAIT;
              end else begin
                res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_STOP, '0); n_cnt = n_cnt + 1'b1;
                polls_nxt = poll_load;
                res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_START, '0); n_cnt = n_cnt + 1'b1;
                phase_nxt = PH_P_START;
              end
            end
          end
          PH_P_START: begin
            if (in_ch.bus_status != ST_START_OK && in_ch.bus_status != ST_RSTART_OK) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_STOP, '0); n_cnt = n_cnt + 1'b1;
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_SEND,
                                                 dev_byte(device_base_r, addr_r, 1'b0));
              n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_P_DEV;
            end
          end
          PH_P_DEV: begin
            polls_nxt = polls_dec;
            res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_STOP, '0); n_cnt = n_cnt + 1'b1;
            if (in_ch.bus_status == ST_WADDR_ACK) begin
              addr_nxt = addr_step;
              rem_nxt  = rem_step;
              if (kind_r == KIND_SPLIT && rem_step != '0) begin
                chunk_nxt = wc2[CHUNK_W-1:0];
                res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_START, '0); n_cnt = n_cnt + 1'b1;
                phase_nxt = PH_W_START;
              end else begin
                res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_OK, '0); n_cnt = n_cnt + 1'b1;
                phase_nxt = PH_IDLE;
              end
            end else if (polls_dec != '0) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_START, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_P_START;
            end else begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
          PH_R_WORD: begin
            if (in_ch.bus_status != ST_DATA_ACK) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_RSTART, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_R_RSTART;
            end
          end
          PH_R_RSTART: begin
            if (in_ch.bus_status != ST_RSTART_OK) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_SEND,
                                                 dev_byte(device_base_r, addr_r, 1'b1));
              n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_R_RDEV;
            end
          end
          PH_R_RDEV: begin
            if (in_ch.bus_status != ST_RADDR_ACK) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_ERR, '0); n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res((chunk_r == CHUNK_W'(1)) ?
                                                 ACT_RECV_NACK : ACT_RECV_ACK, '0);
              n_cnt = n_cnt + 1'b1;
              phase_nxt = PH_R_DATA;
            end
          end
          PH_R_DATA: begin
            // status is not checked after a receive
            res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_READ, in_ch.data_byte);
            n_cnt = n_cnt + 1'b1;
            addr_nxt  = addr_inc;
            rem_nxt   = rem_dec;
            chunk_nxt = chunk_dec;
            if (chunk_dec != '0) begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res((chunk_dec == CHUNK_W'(1)) ?
                                                 ACT_RECV_NACK : ACT_RECV_ACK, '0);
              n_cnt = n_cnt + 1'b1;
            end else begin
              res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_STOP, '0); n_cnt = n_cnt + 1'b1;
              if (rem_dec != '0) begin
                chunk_nxt = rc2;
                res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_START, '0); n_cnt = n_cnt + 1'b1;
                phase_nxt = PH_R_START;
              end else begin
                res[n_cnt[RES_IDX_W-1:0]] = mk_res(ACT_OK, '0); n_cnt = n_cnt + 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end else begin
        // any other word in this phase is dropped without a result
      end
    end

    if (n_cnt != '0) begin
      res[RES_IDX_W'(n_cnt - RES_CNT_W'(1))].last = 1'b1;
    end
  end

  assign push.n   = n_cnt;
  assign push.res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= '0;
      addr_r  <= '0;
      rem_r   <= '0;
      chunk_r <= '0;
      polls_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      addr_r  <= addr_nxt;
      rem_r   <= rem_nxt;
      chunk_r <= chunk_nxt;
      polls_r <= polls_nxt;
    end
  end

  i2cee_res_fifo u_res_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

  a_res_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != '0 |-> in_fire)
    else $error("results produced without an accepted word");

  a_host_byte_send: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_W_WAIT && in_ch.command == CMD_HOST_BYTE
      |-> push.n == RES_CNT_W'(1) && push.res[0].action == ACT_SEND)
    else $error("host byte did not produce a single send");

  a_read_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_R_DATA && in_ch.command == CMD_STATUS
      |=> addr_r == $past(addr_r) + ADDR_W'(1))
    else $error("read address did not advance on received byte");

endmodule
`default_nettype wire
